// File: src/bcs_pkg.sv
// shared types and constants for the binned chi-square score block
package bcs_pkg;

  // fixed field widths of the stream channels
  localparam int SAMPLE_W    = 16;
  localparam int STAT_W      = 32;
  localparam int COUNT_W     = 10;
  localparam int OUT_TDATA_W = 48;
  localparam int FRAC_W      = 16;

  // accumulator holds one bit above the statistic to flag saturation
  localparam int SUM_W = STAT_W + 1;
  localparam logic [SUM_W-1:0]   SUM_CAP   = {1'b1, {STAT_W{1'b0}}};
  localparam logic [STAT_W-1:0]  STAT_MAX  = {STAT_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // sequencer states
  typedef enum logic [15:0] {
    S_LOAD   = 16'h0001,
    S_CLR    = 16'h0002,
    S_RD     = 16'h0004,
    S_BIN    = 16'h0008,
    S_BWAIT  = 16'h0010,
    S_CRD    = 16'h0020,
    S_CWR    = 16'h0040,
    S_SRD0   = 16'h0080,
    S_SRD1   = 16'h0100,
    S_SRD2   = 16'h0200,
    S_TERM1  = 16'h0400,
    S_TERM2  = 16'h0800,
    S_TERM3  = 16'h1000,
    S_CSTART = 16'h2000,
    S_CWAIT  = 16'h4000,
    S_OUT    = 16'h8000
  } state_t;

  // status of a serial divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: src/bcs_ram.sv
// generic single-write, single-read ram with registered read data
module bcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/bcs_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module bcs_div #(
  parameter int NUM_W = 8,
  parameter int DEN_W = 4,
  parameter int Q_W   = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_W-1:0]    num,
  input  logic [DEN_W-1:0]    den,
  output logic [Q_W-1:0]      quo,
  output bcs_pkg::div_status_t status
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [Q_W-1:0]   low_r, low_nxt;
  logic [Q_W-1:0]   quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // one trial subtraction of the shifted remainder
  assign trial = {rem_r, low_r[Q_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    low_nxt  = low_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      // the high part is already below the divisor
      rem_nxt  = DEN_W'(num >> Q_W);
      low_nxt  = num[Q_W-1:0];
      den_nxt  = den;
      quo_nxt  = '0;
      cnt_nxt  = CNT_W'(Q_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_nxt = low_r << 1;
      quo_nxt = {quo_r[Q_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    low_r <= low_nxt;
    quo_r <= quo_nxt;
  end

  assign quo         = quo_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

// File: src/binned_chi_square_score.sv
// top level of the binned chi-square score block
//
// input channel: one transaction per sample, tdata carries the feature value,
// tuser the class label (1 positive) and tlast marks the final sample of a run.
// while loading, samples are taken one per cycle and written to the sample
// store while the running min and max are kept; beyond MAX_SAMPLES samples are
// dropped and the result is flagged as saturated.
// after the last sample the block stops taking input and works on the run:
// the bin counters are cleared, each stored sample is binned through the
// serial bin divider (skipped when min equals max) and counted, and each of
// the 2*NUM_BINS table cells is scored through the serial term divider
// (skipped for a cell with zero expectation), after the counters of its bin
// are read in S_SRD0 to S_SRD2.
// output channel: one transaction per run, tdata carries the statistic (16
// fractional bits) and the sample count, tuser the saturation flag.
// the result sits in an output register; the next run is loaded while it
// waits, and only the hand-over of the following result waits for the
// receiver to take it.
// reset empties the run and clears the output valid; counters are cleared at
// the start of every run's computation, so no clearing pass follows reset.
module binned_chi_square_score #(
  parameter int MAX_SAMPLES = 512,
  parameter int NUM_BINS    = 25,
  parameter int VALUE_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bcs_pkg::SAMPLE_W-1:0]       in_tdata,  // [15:0] sample_value
  input  logic                               in_tuser,  // [0] class_bit
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bcs_pkg::OUT_TDATA_W-1:0]    out_tdata, // [31:0] chi_square, [41:32] sample_count
  output logic                               out_tuser  // [0] saturated
);

  localparam int VB     = VALUE_BITS;
  localparam int LW     = $clog2(MAX_SAMPLES + 1);
  localparam int AW     = $clog2(MAX_SAMPLES);
  localparam int QW     = $clog2(NUM_BINS + 1);
  localparam int BW     = $clog2(NUM_BINS);
  localparam int CAW    = $clog2(2 * NUM_BINS);
  localparam int SW     = VB + 1;
  localparam int BNUM_W = VB + QW;
  localparam int CNUM_W = 4 * LW + bcs_pkg::FRAC_W;
  localparam int CDEN_W = 3 * LW;
  localparam int CQ_W   = LW + bcs_pkg::FRAC_W;
  localparam int SUM_W  = bcs_pkg::SUM_W;

  bcs_pkg::state_t state_r, state_nxt;

  logic [VB-1:0]     min_r, min_nxt;
  logic [VB-1:0]     max_r, max_nxt;
  logic [LW-1:0]     run_len_r, run_len_nxt;
  logic              ovf_r, ovf_nxt;
  logic [LW-1:0]     idx_r, idx_nxt;
  logic [CAW-1:0]    clr_idx_r, clr_idx_nxt;
  logic [CAW-1:0]    caddr_r, caddr_nxt;
  logic              cls_r, cls_nxt;
  logic [LW-1:0]     col0_r, col0_nxt;
  logic [LW-1:0]     col1_r, col1_nxt;
  logic [BW-1:0]     bidx_r, bidx_nxt;
  logic              kidx_r, kidx_nxt;
  logic [LW-1:0]     cnt0_r, cnt0_nxt;
  logic [LW-1:0]     cnt1_r, cnt1_nxt;
  logic [2*LW-1:0]   rc_r, rc_nxt;
  logic [2*LW-1:0]   ot_r, ot_nxt;
  logic [2*LW-1:0]   d_r, d_nxt;
  logic [4*LW-1:0]   dsq_r, dsq_nxt;
  logic [CDEN_W-1:0] den_r, den_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [bcs_pkg::STAT_W-1:0]  out_stat_r, out_stat_nxt;
  logic [bcs_pkg::COUNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic                        out_sat_r, out_sat_nxt;

  // store and counter ram ports
  logic              st_we;
  logic [SW-1:0]     st_rdata;
  logic              cn_we;
  logic [CAW-1:0]    cn_waddr, cn_raddr;
  logic [LW-1:0]     cn_wdata, cn_rdata;

  // divider ports
  logic                 bdiv_start, cdiv_start;
  logic [BNUM_W-1:0]    bnum;
  logic [QW-1:0]        bq;
  logic [CQ_W-1:0]      cq;
  bcs_pkg::div_status_t bdiv_st, cdiv_st;

  logic [VB-1:0]     v_in;
  logic [VB-1:0]     st_v;
  logic [VB-1:0]     span;
  logic [BW-1:0]     bin_sel;
  logic [LW-1:0]     row, col_k, obs_k;
  logic [SUM_W:0]    sum_add;
  logic              in_acc;

  assign in_acc = in_tvalid && in_tready;
  assign v_in   = VB'(in_tdata);
  assign st_v   = st_rdata[SW-1:1];
  assign span   = max_r - min_r;

  // offset times bin count feeds the bin divider
  assign bnum = BNUM_W'(VB'(st_v - min_r)) * BNUM_W'(NUM_BINS);

  // clamp to the top bin
  assign bin_sel = (bq > QW'(NUM_BINS - 1)) ? BW'(NUM_BINS - 1) : BW'(bq);

  // cell operands for the current bin and class
  assign row   = LW'({1'b0, cnt0_r} + {1'b0, cnt1_r});
  assign col_k = kidx_r ? col1_r : col0_r;
  assign obs_k = kidx_r ? cnt1_r : cnt0_r;

  assign sum_add = (SUM_W + 1)'(sum_r) + (SUM_W + 1)'(cq);

  bcs_ram #(.WIDTH(SW), .DEPTH(MAX_SAMPLES)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (run_len_r[AW-1:0]),
    .wdata ({v_in, in_tuser}),
    .raddr (idx_r[AW-1:0]),
    .rdata (st_rdata)
  );

  bcs_ram #(.WIDTH(LW), .DEPTH(2 * NUM_BINS)) u_counts (
    .clk   (clk),
    .we    (cn_we),
    .waddr (cn_waddr),
    .wdata (cn_wdata),
    .raddr (cn_raddr),
    .rdata (cn_rdata)
  );

  bcs_div #(.NUM_W(BNUM_W), .DEN_W(VB), .Q_W(QW)) u_bin_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (bdiv_start),
    .num    (bnum),
    .den    (span),
    .quo    (bq),
    .status (bdiv_st)
  );

  bcs_div #(.NUM_W(CNUM_W), .DEN_W(CDEN_W), .Q_W(CQ_W)) u_term_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cdiv_start),
    .num    ({dsq_r, {bcs_pkg::FRAC_W{1'b0}}}),
    .den    (den_r),
    .quo    (cq),
    .status (cdiv_st)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    run_len_nxt   = run_len_r;
    ovf_nxt       = ovf_r;
    idx_nxt       = idx_r;
    clr_idx_nxt   = clr_idx_r;
    caddr_nxt     = caddr_r;
    cls_nxt       = cls_r;
    col0_nxt      = col0_r;
    col1_nxt      = col1_r;
    bidx_nxt      = bidx_r;
    kidx_nxt      = kidx_r;
    cnt0_nxt      = cnt0_r;
    cnt1_nxt      = cnt1_r;
    rc_nxt        = rc_r;
    ot_nxt        = ot_r;
    d_nxt         = d_r;
    dsq_nxt       = dsq_r;
    den_nxt       = den_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    out_stat_nxt  = out_stat_r;
    out_cnt_nxt   = out_cnt_r;
    out_sat_nxt   = out_sat_r;
    st_we         = 1'b0;
    cn_we         = 1'b0;
    cn_waddr      = caddr_r;
    cn_wdata      = cn_rdata + 1'b1;
    cn_raddr      = caddr_r;
    bdiv_start    = 1'b0;
    cdiv_start    = 1'b0;

    // output transaction taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      bcs_pkg::S_LOAD: begin
        if (in_acc) begin
          if (run_len_r < LW'(MAX_SAMPLES)) begin
            st_we       = 1'b1;
            run_len_nxt = run_len_r + 1'b1;
            if (v_in < min_r) begin
              min_nxt = v_in;
            end
            if (v_in > max_r) begin
              max_nxt = v_in;
            end
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            clr_idx_nxt = '0;
            state_nxt   = bcs_pkg::S_CLR;
          end
        end
      end
      bcs_pkg::S_CLR: begin
        cn_we       = 1'b1;
        cn_waddr    = clr_idx_r;
        cn_wdata    = '0;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == CAW'(2 * NUM_BINS - 1)) begin
          idx_nxt   = '0;
          col0_nxt  = '0;
          col1_nxt  = '0;
          sum_nxt   = '0;
          state_nxt = bcs_pkg::S_RD;
        end
      end
      bcs_pkg::S_RD: begin
        state_nxt = bcs_pkg::S_BIN;
      end
      bcs_pkg::S_BIN: begin
        cls_nxt = st_rdata[0];
        if (span == '0) begin
          caddr_nxt = {BW'(0), ~st_rdata[0]};
          state_nxt = bcs_pkg::S_CRD;
        end else begin
          bdiv_start = 1'b1;
          state_nxt  = bcs_pkg::S_BWAIT;
        end
      end
      bcs_pkg::S_BWAIT: begin
        if (bdiv_st.done) begin
          caddr_nxt = {bin_sel, ~cls_r};
          state_nxt = bcs_pkg::S_CRD;
        end
      end
      bcs_pkg::S_CRD: begin
        state_nxt = bcs_pkg::S_CWR;
      end
      bcs_pkg::S_CWR: begin
        cn_we = 1'b1;
        if (cls_r) begin
          col0_nxt = col0_r + 1'b1;
        end else begin
          col1_nxt = col1_r + 1'b1;
        end
        if (idx_r + 1'b1 == run_len_r) begin
          bidx_nxt  = '0;
          state_nxt = bcs_pkg::S_SRD0;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = bcs_pkg::S_RD;
        end
      end
      bcs_pkg::S_SRD0: begin
        cn_raddr  = {bidx_r, 1'b0};
        state_nxt = bcs_pkg::S_SRD1;
      end
      bcs_pkg::S_SRD1: begin
        cn_raddr  = {bidx_r, 1'b1};
        cnt0_nxt  = cn_rdata;
        state_nxt = bcs_pkg::S_SRD2;
      end
      bcs_pkg::S_SRD2: begin
        cnt1_nxt  = cn_rdata;
        kidx_nxt  = 1'b0;
        state_nxt = bcs_pkg::S_TERM1;
      end
      bcs_pkg::S_TERM1: begin
        rc_nxt    = (2 * LW)'(row) * (2 * LW)'(col_k);
        ot_nxt    = (2 * LW)'(obs_k) * (2 * LW)'(run_len_r);
        state_nxt = bcs_pkg::S_TERM2;
      end
      bcs_pkg::S_TERM2: begin
        d_nxt = (ot_r > rc_r) ? (ot_r - rc_r) : (rc_r - ot_r);
        if (rc_r == '0) begin
          // zero expectation, the cell adds nothing
          if (!kidx_r) begin
            kidx_nxt  = 1'b1;
            state_nxt = bcs_pkg::S_TERM1;
          end else if (bidx_r == BW'(NUM_BINS - 1)) begin
            state_nxt = bcs_pkg::S_OUT;
          end else begin
            bidx_nxt  = bidx_r + 1'b1;
            state_nxt = bcs_pkg::S_SRD0;
          end
        end else begin
          state_nxt = bcs_pkg::S_TERM3;
        end
      end
      bcs_pkg::S_TERM3: begin
        dsq_nxt   = (4 * LW)'(d_r) * (4 * LW)'(d_r);
        den_nxt   = CDEN_W'(rc_r) * CDEN_W'(run_len_r);
        state_nxt = bcs_pkg::S_CSTART;
      end
      bcs_pkg::S_CSTART: begin
        cdiv_start = 1'b1;
        state_nxt  = bcs_pkg::S_CWAIT;
      end
      bcs_pkg::S_CWAIT: begin
        if (cdiv_st.done) begin
          // saturating accumulate of the term
          if (sum_add > (SUM_W + 1)'(bcs_pkg::STAT_MAX)) begin
            sum_nxt = bcs_pkg::SUM_CAP;
          end else begin
            sum_nxt = sum_add[SUM_W-1:0];
          end
          if (!kidx_r) begin
            kidx_nxt  = 1'b1;
            state_nxt = bcs_pkg::S_TERM1;
          end else if (bidx_r == BW'(NUM_BINS - 1)) begin
            state_nxt = bcs_pkg::S_OUT;
          end else begin
            bidx_nxt  = bidx_r + 1'b1;
            state_nxt = bcs_pkg::S_SRD0;
          end
        end
      end
      bcs_pkg::S_OUT: begin
        // hand over once the output register is free
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          out_stat_nxt  = sum_r[SUM_W-1] ? bcs_pkg::STAT_MAX : sum_r[bcs_pkg::STAT_W-1:0];
          out_sat_nxt   = ovf_r || sum_r[SUM_W-1];
          if (32'(run_len_r) > 32'(bcs_pkg::COUNT_MAX)) begin
            out_cnt_nxt = bcs_pkg::COUNT_MAX;
            out_sat_nxt = 1'b1;
          end else begin
            out_cnt_nxt = bcs_pkg::COUNT_W'(run_len_r);
          end
          min_nxt     = '1;
          max_nxt     = '0;
          run_len_nxt = '0;
          ovf_nxt     = 1'b0;
          state_nxt   = bcs_pkg::S_LOAD;
        end
      end
      default: begin
        state_nxt = bcs_pkg::S_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bcs_pkg::S_LOAD;
      min_r       <= '1;
      max_r       <= '0;
      run_len_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      clr_idx_r   <= '0;
      bidx_r      <= '0;
      kidx_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      run_len_r   <= run_len_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      clr_idx_r   <= clr_idx_nxt;
      bidx_r      <= bidx_nxt;
      kidx_r      <= kidx_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    caddr_r    <= caddr_nxt;
    cls_r      <= cls_nxt;
    col0_r     <= col0_nxt;
    col1_r     <= col1_nxt;
    cnt0_r     <= cnt0_nxt;
    cnt1_r     <= cnt1_nxt;
    rc_r       <= rc_nxt;
    ot_r       <= ot_nxt;
    d_r        <= d_nxt;
    dsq_r      <= dsq_nxt;
    den_r      <= den_nxt;
    sum_r      <= sum_nxt;
    out_stat_r <= out_stat_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  assign in_tready  = (state_r == bcs_pkg::S_LOAD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = bcs_pkg::OUT_TDATA_W'({out_cnt_r, out_stat_r});
  assign out_tuser  = out_sat_r;

  // run length never passes the store depth
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    run_len_r <= LW'(MAX_SAMPLES))
    else $error("run length beyond store depth");

  // bin divider is never started on an empty span
  a_no_zero_span: assert property (@(posedge clk) disable iff (!rst_n)
    bdiv_start |-> (span != '0))
    else $error("bin divider started with zero span");

  // a new result only appears from the hand-over state
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == bcs_pkg::S_OUT))
    else $error("result raised outside hand-over");

  // the term divider is idle whenever it is started
  a_cdiv_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cdiv_start |-> !cdiv_st.busy)
    else $error("term divider restarted while busy");

endmodule

// File: bench/binned_chi_square_score_tb.sv
// self-checking testbench for the binned chi-square score block
module binned_chi_square_score_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_SAMPLES = 512;
  localparam int NUM_BINS    = 25;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int HOLD_OFF    = 8000;

  typedef struct {
    logic [bcs_pkg::SAMPLE_W-1:0] value;
    logic                         label;
    logic                         last;
  } sample_t;

  typedef struct {
    logic [bcs_pkg::STAT_W-1:0]  stat;
    logic [bcs_pkg::COUNT_W-1:0] count;
    logic                        sat;
  } score_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [bcs_pkg::SAMPLE_W-1:0] in_tdata;      // [15:0] sample_value
  logic in_tuser;                              // [0] class_bit
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [bcs_pkg::OUT_TDATA_W-1:0] out_tdata;  // [31:0] chi_square, [41:32] sample_count
  logic out_tuser;                             // [0] saturated

  binned_chi_square_score dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  sample_t pending_samples[$];
  score_t  expected_scores[$];
  // samples of the run being collected
  logic [bcs_pkg::SAMPLE_W-1:0] run_vals[$];
  logic                         run_labels[$];
  logic                         run_dropped;
  int errors, cycles, scores_seen, runs_sent, overflow_runs, samples_sent;
  logic in_taken;
  logic stim_done;

  // chi-square of the collected run, with the accumulator capped above 32 bits
  function automatic longint unsigned chi_square_of_run();
    longint unsigned counts[NUM_BINS][2];
    longint unsigned colsum[2];
    longint unsigned total, sum, row, rc, ot, d, num, den, bin;
    int unsigned lo, hi, span;
    lo = 32'hFFFF;
    hi = 0;
    sum = 0;
    colsum[0] = 0;
    colsum[1] = 0;
    foreach (counts[b, k]) counts[b][k] = 0;
    foreach (run_vals[i]) begin
      if (run_vals[i] < lo) lo = run_vals[i];
      if (run_vals[i] > hi) hi = run_vals[i];
    end
    span = hi - lo;
    foreach (run_vals[i]) begin
      bin = 0;
      if (span != 0) begin
        bin = (longint'(run_vals[i] - lo) * NUM_BINS) / span;
        if (bin > NUM_BINS - 1) bin = NUM_BINS - 1;
      end
      // column 0 counts positives, column 1 negatives
      counts[bin][run_labels[i] ? 0 : 1]++;
    end
    for (int b = 0; b < NUM_BINS; b++) begin
      colsum[0] += counts[b][0];
      colsum[1] += counts[b][1];
    end
    total = run_vals.size();
    if (total == 0) return 0;
    for (int b = 0; b < NUM_BINS; b++) begin
      row = counts[b][0] + counts[b][1];
      for (int k = 0; k < 2; k++) begin
        rc = row * colsum[k];
        if (rc == 0) continue;
        ot = counts[b][k] * total;
        d = (ot > rc) ? ot - rc : rc - ot;
        num = d * d;
        den = rc * total;
        sum += ((num / den) << bcs_pkg::FRAC_W) + (((num % den) << bcs_pkg::FRAC_W) / den);
        if (sum > 64'hFFFF_FFFF) sum = 64'h1_0000_0000;
      end
    end
    return sum;
  endfunction

  // queue one run of samples; value style picks the spread of values
  task automatic add_run(input int len, input int style);
    sample_t s;
    logic [bcs_pkg::SAMPLE_W-1:0] base;
    base = bcs_pkg::SAMPLE_W'($urandom);
    for (int i = 0; i < len; i++) begin
      case (style)
        0: s.value = bcs_pkg::SAMPLE_W'($urandom);
        1: s.value = bcs_pkg::SAMPLE_W'(base + $urandom_range(0, 60));
        2: s.value = base;
        default: s.value = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      endcase
      s.label = ($urandom_range(0, 1) != 0);
      s.last  = (i == len - 1);
      pending_samples.push_back(s);
    end
    runs_sent++;
    samples_sent += len;
    if (len > MAX_SAMPLES) overflow_runs++;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // stimulus
  initial begin
    sample_t s;
    stim_done = 1'b0;
    rst_n = 1'b0;
    // single-sample run
    s.value = 16'h1234; s.label = 1'b1; s.last = 1'b1;
    pending_samples.push_back(s);
    runs_sent = 1; samples_sent = 1;
    // equal min and max, and one class only
    s.value = 16'h0000; s.label = 1'b0; s.last = 1'b0;
    pending_samples.push_back(s);
    pending_samples.push_back(s);
    s.last = 1'b1;
    pending_samples.push_back(s);
    runs_sent++; samples_sent += 3;
    // extremes of the value range with mixed labels, then a random and an equal-value run
    add_run(6, 3);
    add_run(8, 0);
    add_run(5, 2);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // random runs, mostly short, one that overflows the store
    while (samples_sent < 850) begin
      if (runs_sent == 30) add_run(MAX_SAMPLES + $urandom_range(1, 6), $urandom_range(0, 3));
      else if ($urandom_range(0, 9) == 0) add_run($urandom_range(20, 40), $urandom_range(0, 3));
      else add_run($urandom_range(1, 10), $urandom_range(0, 3));
    end
    stim_done = 1'b1;
  end

  // driver: one new transaction per falling edge once the previous one is taken and no random gap is pending
  int gap_left;
  always @(negedge clk) begin
    logic v;
    sample_t s;
    v = in_tvalid;
    if (!rst_n) begin
      v = 1'b0;
    end else if (in_tvalid && !in_taken) begin
      v = 1'b1;
    end else if (gap_left > 0) begin
      gap_left--;
      v = 1'b0;
    end else if (pending_samples.size() > 0) begin
      s = pending_samples.pop_front();
      in_tdata <= s.value;
      in_tuser <= s.label;
      in_tlast <= s.last;
      v = 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: gap_left = 0;
        6, 7, 8: gap_left = $urandom_range(1, 3);
        default: gap_left = $urandom_range(5, 40);
      endcase
    end else begin
      v = 1'b0;
    end
    in_tvalid <= v;
  end

  // receiver ready with random stalls and one long hold-off
  int stall_left;
  logic held_off;
  always @(negedge clk) begin
    if (!held_off && scores_seen == 2) begin
      held_off <= 1'b1;
      stall_left <= HOLD_OFF;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      case ($urandom_range(0, 9))
        0, 1: stall_left <= $urandom_range(1, 3);
        2: stall_left <= $urandom_range(10, 60);
        default: stall_left <= 0;
      endcase
      out_tready <= 1'b1;
    end
  end

  initial begin
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    gap_left = 0;
    stall_left = 0;
    held_off = 1'b0;
    in_taken = 1'b0;
    errors = 0;
    cycles = 0;
    scores_seen = 0;
    run_dropped = 1'b0;
  end

  // monitor: predict on each input transaction, check each output transaction
  always @(posedge clk) begin
    score_t want;
    longint unsigned stat;
    cycles++;
    in_taken = in_tvalid && in_tready && rst_n;
    if (in_taken) begin
      if (run_vals.size() < MAX_SAMPLES) begin
        run_vals.push_back(in_tdata);
        run_labels.push_back(in_tuser);
      end else begin
        run_dropped = 1'b1;
      end
      if (in_tlast) begin
        stat = chi_square_of_run();
        want.sat = run_dropped;
        if (stat > 64'hFFFF_FFFF) begin
          stat = 64'hFFFF_FFFF;
          want.sat = 1'b1;
        end
        want.stat = stat[bcs_pkg::STAT_W-1:0];
        want.count = bcs_pkg::COUNT_W'(run_vals.size());
        expected_scores.push_back(want);
        run_vals.delete();
        run_labels.delete();
        run_dropped = 1'b0;
      end
    end
    if (rst_n && out_tvalid && out_tready) begin
      scores_seen++;
      if (expected_scores.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        want = expected_scores.pop_front();
        if (out_tdata[31:0] !== want.stat) begin
          $error("chi_square expected %0h actual %0h", want.stat, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[41:32] !== want.count) begin
          $error("sample_count expected %0d actual %0d", want.count, out_tdata[41:32]);
          errors++;
        end
        if (out_tuser !== want.sat) begin
          $error("saturated expected %0b actual %0b", want.sat, out_tuser);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL binned_chi_square_score");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    while (pending_samples.size() > 0 || in_tvalid) @(posedge clk);
    while (expected_scores.size() > 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    $display("%0d runs of %0d samples sent, %0d results checked, %0d runs overflowed the store",
             runs_sent, samples_sent, scores_seen, overflow_runs);
    if (errors == 0 && expected_scores.size() == 0) begin
      $display("PASS binned_chi_square_score");
    end else begin
      $display("FAIL binned_chi_square_score");
    end
    $finish;
  end

endmodule

// File: files.f
src/bcs_pkg.sv
src/bcs_ram.sv
src/bcs_div.sv
src/binned_chi_square_score.sv
bench/binned_chi_square_score_tb.sv
